@@ rtl/core/microprice_velocity_window_macros.svh @@
// Assertion macros shared by the microprice velocity window RTL
`ifndef MICROPRICE_VELOCITY_WINDOW_MACROS_SVH
`define MICROPRICE_VELOCITY_WINDOW_MACROS_SVH

// checked outside reset
`define MPVW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define MPVW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/mpvw_pkg.sv @@
// Shared types and constants for the microprice velocity window
package mpvw_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int RING_DEPTH = MAX_WINDOW + 1;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int WIN_W      = 9;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int DATA_W     = 32;
  localparam int DP_W       = DATA_W + 1;
  localparam int SUM_W      = 41;
  localparam int W7_W       = 12;
  localparam int NUM_W      = 45;
  localparam int DEN_W      = 12;
  localparam int DIV_STEPS  = NUM_W;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(16);

  typedef struct packed {
    logic signed [DATA_W-1:0] mid_price;
    logic signed [DATA_W-1:0] ofi_sample;
    logic                     series_start;
  } mpvw_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] velocity;
    logic                     warmed_up;
    logic                     saturated;
  } mpvw_out_t;

  typedef struct packed {
    logic accept;
    logic read;
    logic calc;
    logic mul;
    logic add;
    logic absval;
    logic div_start;
    logic finish;
  } mpvw_cmd_t;

  typedef struct packed {
    logic warmed;
    logic div_done;
    logic out_free;
  } mpvw_status_t;

endpackage

@@ rtl/core/mpvw_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle
module mpvw_div
  import mpvw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output logic             done
);

  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              qbit;

  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    diff  = trial - {1'b0, den};
    qbit  = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_STEPS);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], qbit};
      rem <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/core/mpvw_dp.sv @@
// Datapath: history rings, window sum, velocity arithmetic and result register
module mpvw_dp
  import mpvw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  mpvw_cmd_t        cmd,
  output mpvw_status_t     status,
  input  mpvw_in_t         sample,
  input  logic             window_length_we,
  input  logic [WIN_W-1:0] window_length,
  output logic             result_valid,
  input  logic             result_stall,
  output mpvw_out_t        result
);

  `include "microprice_velocity_window_macros.svh"

  logic [DATA_W-1:0] price_mem [RING_DEPTH];
  logic [DATA_W-1:0] ofi_mem [RING_DEPTH];

  logic [WIN_W-1:0]         win_reg;
  logic [WIN_W-1:0]         w;
  logic signed [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         pos;
  mpvw_in_t                 item;
  logic [DATA_W-1:0]        old_price;
  logic [DATA_W-1:0]        old_ofi;
  logic signed [DP_W-1:0]   dp;
  logic                     warm;
  logic signed [NUM_W-1:0]  prod;
  logic signed [NUM_W-1:0]  sum3;
  logic [DEN_W-1:0]         fivew;
  logic [DEN_W-1:0]         den;
  logic signed [NUM_W-1:0]  num;
  logic                     neg;
  logic [NUM_W-1:0]         rnd;
  logic [NUM_W-1:0]         quo;
  logic                     div_done;

  logic [IDX_W:0]           praw;
  logic [IDX_W:0]           oraw;
  logic [IDX_W-1:0]         paddr;
  logic [IDX_W-1:0]         oaddr;
  logic                     warm_now;
  logic                     drop_old;
  logic signed [SUM_W-1:0]  sum_next;
  logic [W7_W-1:0]          w7;
  logic signed [NUM_W:0]    prod_full;
  logic signed [NUM_W-1:0]  sum_ext;
  logic                     sat_hi;
  logic                     sat_lo;
  logic [DATA_W-1:0]        qlow;
  logic out_free;

  always_comb begin
    if (win_reg == '0) begin
      w = WIN_W'(1);
    end else if (win_reg > WIN_W'(MAX_WINDOW)) begin
      w = WIN_W'(MAX_WINDOW);
    end else begin
      w = win_reg;
    end
  end

  always_comb begin
    praw = {1'b0, pos} + (IDX_W+1)'(RING_DEPTH) - {1'b0, w};
    oraw = {1'b0, pos} + (IDX_W+1)'(RING_DEPTH - 1) - {1'b0, w};
    paddr = (praw >= (IDX_W+1)'(RING_DEPTH)) ?
            IDX_W'(praw - (IDX_W+1)'(RING_DEPTH)) : praw[IDX_W-1:0];
    oaddr = (oraw >= (IDX_W+1)'(RING_DEPTH)) ?
            IDX_W'(oraw - (IDX_W+1)'(RING_DEPTH)) : oraw[IDX_W-1:0];
  end

  always_comb begin
    warm_now = (count >= CNT_W'(w));
    drop_old = (count >= (CNT_W'(w) + CNT_W'(1)));
    sum_next = sum + SUM_W'(item.ofi_sample)
             - (drop_old ? SUM_W'($signed(old_ofi)) : SUM_W'(0));
    w7       = W7_W'(w) * W7_W'(7);
    prod_full = $signed({1'b0, w7}) * dp;
    sum_ext  = NUM_W'(sum);
  end

  // series state
  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg <= WINDOW_RESET;
      sum     <= '0;
      count   <= '0;
      pos     <= '0;
    end else if (window_length_we) begin
      win_reg <= window_length;
      sum     <= '0;
      count   <= '0;
      pos     <= '0;
    end else if (cmd.accept && sample.series_start) begin
      sum   <= '0;
      count <= '0;
      pos   <= '0;
    end else if (cmd.calc) begin
      sum   <= sum_next;
      pos   <= (pos == IDX_W'(RING_DEPTH - 1)) ? '0 : pos + IDX_W'(1);
      if (count < CNT_W'(RING_DEPTH)) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      old_price <= price_mem[paddr];
      old_ofi   <= ofi_mem[oaddr];
    end
    if (cmd.calc) begin
      price_mem[pos] <= item.mid_price;
      ofi_mem[pos]   <= item.ofi_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= sample;
    end
    if (cmd.calc) begin
      dp   <= DP_W'(item.mid_price) - DP_W'($signed(old_price));
      warm <= warm_now;
    end
    if (cmd.mul) begin
      prod  <= prod_full[NUM_W-1:0];
      sum3  <= (sum_ext <<< 1) + sum_ext;
      fivew <= DEN_W'(w) * DEN_W'(5);
      den   <= DEN_W'(w) * DEN_W'(10);
    end
    if (cmd.add) begin
      num <= prod + sum3;
    end
    if (cmd.absval) begin
      neg <= num[NUM_W-1];
      rnd <= num[NUM_W-1] ? (NUM_W'(fivew) - NUM_W'(num)) : (NUM_W'(num) + NUM_W'(fivew));
    end
  end

  mpvw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rnd),
    .divisor  (den),
    .quotient (quo),
    .done     (div_done)
  );

  always_comb begin
    sat_hi = !neg && (quo > NUM_W'(33'h0_7FFF_FFFF));
    sat_lo = neg && (quo > NUM_W'(33'h0_8000_0000));
    qlow   = quo[DATA_W-1:0];
  end

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && out_free) begin
      result.warmed_up <= warm;
      if (!warm) begin
        result.velocity  <= '0;
        result.saturated <= 1'b0;
      end else if (sat_hi) begin
        result.velocity  <= {1'b0, {(DATA_W-1){1'b1}}};
        result.saturated <= 1'b1;
      end else if (sat_lo) begin
        result.velocity  <= {1'b1, {(DATA_W-1){1'b0}}};
        result.saturated <= 1'b1;
      end else begin
        result.velocity  <= neg ? -$signed(qlow) : $signed(qlow);
        result.saturated <= 1'b0;
      end
    end
  end

  assign status.warmed   = warm_now;
  assign status.div_done = div_done;
  assign status.out_free = out_free;

  `MPVW_ASSERT(a_pos_range, (pos < IDX_W'(RING_DEPTH - 1)) || (pos == IDX_W'(RING_DEPTH - 1)), "write position out of ring")
  `MPVW_ASSERT(a_count_range, count <= CNT_W'(RING_DEPTH), "sample count beyond ring depth")
  `MPVW_ASSERT(a_cfg_clears, window_length_we |=> (count == '0 && pos == '0 && sum == '0), "window write did not clear series")
  `MPVW_ASSERT(a_warmup_zero, (result_valid && !result.warmed_up) |-> (result.velocity == '0 && !result.saturated), "nonzero result during warm-up")

endmodule

@@ rtl/core/mpvw_ctrl.sv @@
// Controller: sequences one item through read, calc, then (once warmed up) arithmetic and divide, and result load
module mpvw_ctrl
  import mpvw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         sample_valid,
  output logic         sample_stall,
  input  mpvw_status_t status,
  output mpvw_cmd_t    cmd
);

  `include "microprice_velocity_window_macros.svh"

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_READ = 9'b000000010,
    S_CALC = 9'b000000100,
    S_MUL  = 9'b000001000,
    S_ADD  = 9'b000010000,
    S_ABS  = 9'b000100000,
    S_DIVS = 9'b001000000,
    S_DIVW = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (sample_valid) state_next = S_READ;
      end
      S_READ: state_next = S_CALC;
      S_CALC: state_next = status.warmed ? S_MUL : S_FIN;
      S_MUL:  state_next = S_ADD;
      S_ADD:  state_next = S_ABS;
      S_ABS:  state_next = S_DIVS;
      S_DIVS: state_next = S_DIVW;
      S_DIVW: begin
        if (status.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign sample_stall  = (state != S_IDLE);
  assign cmd.accept    = (state == S_IDLE) && sample_valid;
  assign cmd.read      = (state == S_READ);
  assign cmd.calc      = (state == S_CALC);
  assign cmd.mul       = (state == S_MUL);
  assign cmd.add       = (state == S_ADD);
  assign cmd.absval    = (state == S_ABS);
  assign cmd.div_start = (state == S_DIVS);
  assign cmd.finish    = (state == S_FIN);

  `MPVW_ASSERT(a_accept_reads, cmd.accept |=> (state == S_READ), "accepted item not read next")
  `MPVW_ASSERT(a_div_wait, (state == S_DIVS) |=> !status.div_done, "divider done too early")
  `MPVW_ASSERT(a_fin_hold, (state == S_FIN && !status.out_free) |=> (state == S_FIN), "result dropped while output full")

endmodule

@@ rtl/core/microprice_velocity_window.sv @@
// Top level of the microprice velocity window block
// Usage:
//   Input channel sample/sample_valid/sample_stall carries one mid price, one
//   order-flow-imbalance sample and a series-start flag per item. The block
//   returns one item per input on result/result_valid/result_stall.
//   window_length_we writes window_length; a write also restarts the series.
//   Write it only while the block is idle.
// Sequence:
//   A warmed-up item goes from accept through read, calc, multiply, add,
//   absolute value and the 45-step restoring divider (one quotient bit per
//   cycle) to the result load. Items still in warm-up skip the arithmetic
//   and the divide. One item is worked at a time; the next is accepted the
//   cycle after the result loads.
// Reset:
//   rst clears the series and sets the window to 16. History rings are not
//   cleared; entries read before being written in the current series go unused.
// Backpressure:
//   While result_stall holds a result, the next item is still accepted and
//   processed, then waits in its final state until the output frees up.
module microprice_velocity_window
  import mpvw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  mpvw_in_t         sample,
  input  logic             window_length_we,
  input  logic [WIN_W-1:0] window_length,
  output logic             result_valid,
  input  logic             result_stall,
  output mpvw_out_t        result
);

  mpvw_cmd_t    cmd;
  mpvw_status_t status;

  mpvw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  mpvw_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .sample           (sample),
    .window_length_we (window_length_we),
    .window_length    (window_length),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result           (result)
  );

endmodule
